@@ design/sscs_pkg.sv @@
// shared types, constants and helpers for the substring search block
package sscs_pkg;

   localparam int NEEDLE_MAX_DEF   = 8;
   localparam int HAYSTACK_MAX_DEF = 65536;

   localparam int NEEDLE_W   = 64;
   localparam int NEEDLE_LEN_W = 4;
   localparam int POS_W      = 16;
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NEEDLE_BYTES  = 2'd0,
      CSR_NEEDLE_LENGTH = 2'd1,
      CSR_MATCH_CASE    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] match_position;
      logic             overflow;
   } rsp_type;

   // ascii upper case folds to lower case unless exact compare is asked for
   function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic exact);
      logic [7:0] r;
      r = b;
      if (!exact && b >= 8'h41 && b <= 8'h5A) begin
         r = b + 8'h20;
      end
      return r;
   endfunction

endpackage

@@ design/substring_search_case_option.sv @@
// Streaming first-occurrence substring search with optional ASCII case folding.
//
// The haystack enters one byte per beat on the req_ channel (valid/stall);
// last_byte marks its final byte. Only that final beat produces a response
// on the rsp_ channel: found, start offset of the first match, overflow.
// The needle (up to NEEDLE_MAX bytes), its length and the case mode are set
// through the csr_ write port; the user must write them only while no haystack
// is in flight, which the block does not enforce. csr_ready is always high.
// Configuration survives from one haystack to the next. Throughput is one byte
// per cycle unless a final byte is held: a beat lands in an input register,
// then the shift window is compared against the needle and the search state
// is updated. rsp_valid rises once the final byte enters the response register.
// When the response register is full and rsp_stall is high, an
// input register holding a final byte waits, and req_stall rises; other bytes
// keep flowing. Synchronous reset clears the stream state, empties both
// registers and loads the configuration defaults (empty needle, exact compare).
module substring_search_case_option #(
   parameter int NEEDLE_MAX   = sscs_pkg::NEEDLE_MAX_DEF,
   parameter int HAYSTACK_MAX = sscs_pkg::HAYSTACK_MAX_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  sscs_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output sscs_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sscs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sscs_pkg::NEEDLE_W-1:0]   csr_data
);

   localparam int LEN_W  = $clog2(NEEDLE_MAX + 1);
   localparam int CNT_W  = $clog2(HAYSTACK_MAX + 2);
   localparam int WIDE_W = (CNT_W > sscs_pkg::POS_W) ? CNT_W : sscs_pkg::POS_W;
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(HAYSTACK_MAX);
   localparam logic [WIDE_W-1:0] POS_SAT = WIDE_W'({sscs_pkg::POS_W{1'b1}});

   // configuration
   logic [sscs_pkg::NEEDLE_W-1:0]     needle_ff;
   logic [sscs_pkg::NEEDLE_LEN_W-1:0] needle_len_ff;
   logic                              match_case_ff;

   // input register
   sscs_pkg::req_type s1_ff;
   logic              s1_valid_ff;

   // stream state
   logic [NEEDLE_MAX-1:0][7:0] window_ff;
   logic [NEEDLE_MAX-1:0][7:0] window_in;
   logic [CNT_W-1:0]           cnt_ff;
   logic [CNT_W-1:0]           cnt_in;
   logic                       hit_ff;
   logic                       hit_in;
   logic [sscs_pkg::POS_W-1:0] offset_ff;
   logic [sscs_pkg::POS_W-1:0] offset_in;

   // response register
   sscs_pkg::rsp_type rsp_ff;
   sscs_pkg::rsp_type rsp_in;
   logic              rsp_valid_ff;

   logic              advance;
   logic              over;
   logic              win_hit;
   logic [LEN_W-1:0]  used_len;
   logic [WIDE_W-1:0] start_pos;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_ff     <= '0;
         needle_len_ff <= '0;
         match_case_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            sscs_pkg::CSR_NEEDLE_BYTES:  needle_ff     <= csr_data;
            sscs_pkg::CSR_NEEDLE_LENGTH: needle_len_ff <= csr_data[sscs_pkg::NEEDLE_LEN_W-1:0];
            sscs_pkg::CSR_MATCH_CASE:    match_case_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign used_len = (needle_len_ff > sscs_pkg::NEEDLE_LEN_W'(NEEDLE_MAX)) ?
                     LEN_W'(NEEDLE_MAX) : LEN_W'(needle_len_ff);

   // a final byte moves on only if the response register can take it
   assign advance   = s1_valid_ff && (!s1_ff.last_byte || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_ff <= req_data;
      end
   end

   always_comb begin
      window_in[0] = s1_ff.data_byte;
      for (int i = 1; i < NEEDLE_MAX; i++) begin
         window_in[i] = window_ff[i-1];
      end
   end

   sscs_match #(
      .NEEDLE_MAX (NEEDLE_MAX),
      .LEN_W      (LEN_W)
   ) u_match (
      .window     (window_in),
      .needle     (needle_ff),
      .used_len   (used_len),
      .match_case (match_case_ff),
      .hit        (win_hit)
   );

   always_comb begin
      cnt_in    = (cnt_ff <= CNT_LIMIT) ? cnt_ff + CNT_W'(1) : cnt_ff;
      over      = cnt_in > CNT_LIMIT;
      start_pos = WIDE_W'(cnt_in) - WIDE_W'(used_len);
      hit_in    = hit_ff;
      offset_in = offset_ff;
      if (used_len != '0 && !hit_ff && WIDE_W'(cnt_in) >= WIDE_W'(used_len) && win_hit) begin
         hit_in    = 1'b1;
         offset_in = (over || start_pos > POS_SAT) ? '1 : start_pos[sscs_pkg::POS_W-1:0];
      end
      if (used_len == '0) begin
         rsp_in.found          = 1'b1;
         rsp_in.match_position = '0;
      end else begin
         rsp_in.found          = hit_in;
         rsp_in.match_position = hit_in ? offset_in : '0;
      end
      rsp_in.overflow = over;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         cnt_ff    <= '0;
         hit_ff    <= 1'b0;
         offset_ff <= '0;
      end else if (advance) begin
         if (s1_ff.last_byte) begin
            window_ff <= '0;
            cnt_ff    <= '0;
            hit_ff    <= 1'b0;
            offset_ff <= '0;
         end else begin
            window_ff <= window_in;
            cnt_ff    <= cnt_in;
            hit_ff    <= hit_in;
            offset_ff <= offset_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && s1_ff.last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_ff.last_byte) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_stall_needs_full_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s1_ff.last_byte && rsp_valid_ff))
      else $error("input stalled without a pending final byte and full output");

   a_not_found_zero_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.found) |-> (rsp_ff.match_position == '0))
      else $error("position nonzero on a miss");

   a_hit_sticky: assert property (@(posedge clock) disable iff (reset)
      (hit_ff && !(advance && s1_ff.last_byte)) |=> hit_ff)
      else $error("first-hit flag dropped mid haystack");

   a_cleared_after_last: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_ff.last_byte) |=> (cnt_ff == '0 && !hit_ff && rsp_valid_ff))
      else $error("stream state not cleared after final byte");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_LIMIT + CNT_W'(1))
      else $error("byte counter beyond saturation");
`endif

endmodule

@@ design/sscs_match.sv @@
// window against needle compare for the newest needle_length bytes
module sscs_match #(
   parameter int NEEDLE_MAX = sscs_pkg::NEEDLE_MAX_DEF,
   parameter int LEN_W      = $clog2(NEEDLE_MAX + 1),
   parameter int IDX_W      = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1
) (
   input  logic [NEEDLE_MAX-1:0][7:0]     window,
   input  logic [sscs_pkg::NEEDLE_W-1:0]  needle,
   input  logic [LEN_W-1:0]               used_len,
   input  logic                           match_case,
   output logic                           hit
);

   logic [IDX_W-1:0] idx;

   // needle byte k lines up with window entry used_len-1-k (entry 0 newest)
   always_comb begin
      hit = 1'b1;
      idx = '0;
      for (int k = 0; k < NEEDLE_MAX; k++) begin
         if (LEN_W'(k) < used_len) begin
            idx = IDX_W'(used_len - LEN_W'(k) - LEN_W'(1));
            if (sscs_pkg::fold_byte(needle[8*k +: 8], match_case) !=
                sscs_pkg::fold_byte(window[idx], match_case)) begin
               hit = 1'b0;
            end
         end
      end
   end

endmodule
